[sv/cpiohv_pkg.sv]
// Constants, codes and helper functions for the cpio newc header validator.
package cpiohv_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned SIZE_W    = 34;
  localparam int unsigned RES_W     = 36;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [POS_W-1:0] MAGIC_LEN = 7'd6;
  localparam logic [POS_W-1:0] HDR_LEN   = 7'd110;

  localparam logic [3:0] FIELD_FILESIZE = 4'd6;
  localparam logic [3:0] FIELD_NAMESIZE = 4'd11;
  localparam logic [2:0] LAST_DIGIT     = 3'd7;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_2     = 8'h32;
  localparam logic [7:0] CHAR_7     = 8'h37;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  typedef enum logic [1:0] {
    VERDICT_REJECT     = 2'd0,
    VERDICT_MAGIC_ONLY = 2'd1,
    VERDICT_STRUCTURAL = 2'd2,
    VERDICT_CONSISTENT = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(logic [7:0] c);
    hex_digit_t h;
    h.valid = 1'b0;
    h.value = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      h.valid = 1'b1;
      h.value = 4'(c - CHAR_0);
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      h.valid = 1'b1;
      h.value = 4'(c - CHAR_LA + 8'd10);
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      h.valid = 1'b1;
      h.value = 4'(c - CHAR_UA + 8'd10);
    end
    return h;
  endfunction

endpackage

[sv/cpio_header_validator_core.sv]
// Top level of the cpio newc header validator: byte stream in, one verdict per candidate out.
//
// Takes one header byte per beat and gives at most one verdict per candidate header.
// A beat with s_tuser high opens a candidate and latches the byte count to file end.
// Six magic bytes select newc ("070701"/"070702") or a magic-only verdict; newc then
// needs 104 hex digits in thirteen fields, and the aligned entry size
// align4(110 + namesize) + align4(filesize) is checked against the latched count.
// A beat with s_tlast high means the file ended and carries no byte. Each beat passes
// an input register, one stage of decode and counter logic, and lands in the result
// register, so a beat can be taken in every cycle while m_tready does not hold the result
// register; the verdict is valid once its beat has moved from the input register into it.
module cpio_header_validator_core
  import cpiohv_pkg::*;
#(
  parameter int AVAIL_WIDTH = 40,
  localparam int S_TDATA_W = ((AVAIL_WIDTH + 8 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte, bytes_available, zero fill
  input  logic                 s_tuser,   // start_of_header
  input  logic                 s_tlast,   // end_of_file
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // verdict, entry_size, zero fill
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_start;
  logic [AVAIL_WIDTH-1:0] in_avail;
  logic                   in_eof;

  logic [POS_W-1:0]       byte_position, byte_position_next;
  logic                   newc_magic_match, newc_magic_match_next;
  logic [ACC_W-1:0]       field_accumulator, field_accumulator_next;
  logic [ACC_W-1:0]       file_size_field, file_size_field_next;
  logic [ACC_W-1:0]       name_size_field, name_size_field_next;
  logic [AVAIL_WIDTH-1:0] available_count, available_count_next;
  logic                   verdict_given, verdict_given_next;
  logic [SIZE_W-1:0]      entry_calc;

  verdict_t               res_verdict, res_verdict_next;
  logic [SIZE_W-1:0]      res_size, res_size_next;
  logic                   emit;
  logic                   advance;

  logic [POS_W-1:0]       pos_cur;
  logic                   given_cur;
  logic [POS_W-1:0]       rel;
  logic [ACC_W-1:0]       acc_shift;
  logic                   magic_ok;
  logic                   magic_all;
  hex_digit_t             hex;

  logic [SIZE_W-1:0]      name_plus3;
  logic [SIZE_W-1:0]      file_plus3;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata[7:0];
      in_avail <= s_tdata[8 +: AVAIL_WIDTH];
      in_start <= s_tuser;
      in_eof   <= s_tlast;
    end
  end

  assign name_plus3 = SIZE_W'(name_size_field) + SIZE_W'(HDR_LEN) + SIZE_W'(3);
  assign file_plus3 = SIZE_W'(file_size_field) + SIZE_W'(3);

  always_ff @(posedge clk) begin
    entry_calc <= {name_plus3[SIZE_W-1:2], 2'b00} + {file_plus3[SIZE_W-1:2], 2'b00};
  end

  always_comb begin
    pos_cur   = in_start ? '0 : byte_position;
    given_cur = in_start ? 1'b0 : verdict_given;

    byte_position_next     = pos_cur;
    newc_magic_match_next  = in_start ? 1'b1 : newc_magic_match;
    field_accumulator_next = in_start ? '0 : field_accumulator;
    file_size_field_next   = in_start ? '0 : file_size_field;
    name_size_field_next   = in_start ? '0 : name_size_field;
    available_count_next   = in_start ? in_avail : available_count;

    emit             = 1'b0;
    res_verdict_next = VERDICT_REJECT;
    res_size_next    = '0;

    rel       = pos_cur - MAGIC_LEN;
    hex       = hex_decode(in_byte);
    acc_shift = {field_accumulator_next[ACC_W-5:0], hex.value};

    case (pos_cur[2:0])
      3'd1, 3'd3: magic_ok = (in_byte == CHAR_7);
      3'd5:       magic_ok = (in_byte == CHAR_1) || (in_byte == CHAR_2);
      default:    magic_ok = (in_byte == CHAR_0);
    endcase
    magic_all = newc_magic_match_next && magic_ok;

    if (!given_cur) begin
      if (in_eof) begin
        emit = 1'b1;
      end else if (pos_cur < MAGIC_LEN) begin
        newc_magic_match_next = magic_all;
        byte_position_next    = pos_cur + 1'b1;
        if (pos_cur == MAGIC_LEN - 1'b1 && !magic_all) begin
          emit             = 1'b1;
          res_verdict_next = VERDICT_MAGIC_ONLY;
        end
      end else if (pos_cur < HDR_LEN) begin
        if (!hex.valid) begin
          emit = 1'b1;
        end else begin
          field_accumulator_next = acc_shift;
          if (rel[2:0] == LAST_DIGIT) begin
            if (rel[6:3] == FIELD_FILESIZE) begin
              file_size_field_next = acc_shift;
            end
            if (rel[6:3] == FIELD_NAMESIZE) begin
              name_size_field_next = acc_shift;
            end
            field_accumulator_next = '0;
          end
          byte_position_next = pos_cur + 1'b1;
          if (pos_cur == HDR_LEN - 1'b1) begin
            emit = 1'b1;
            if (entry_calc == '0 || AVAIL_WIDTH'(entry_calc) > available_count_next) begin
              res_verdict_next = VERDICT_STRUCTURAL;
            end else begin
              res_verdict_next = VERDICT_CONSISTENT;
              res_size_next    = entry_calc;
            end
          end
        end
      end
    end

    verdict_given_next = given_cur || emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      newc_magic_match  <= 1'b1;
      field_accumulator <= '0;
      file_size_field   <= '0;
      name_size_field   <= '0;
      available_count   <= '0;
      verdict_given     <= 1'b1;
    end else if (advance) begin
      byte_position     <= byte_position_next;
      newc_magic_match  <= newc_magic_match_next;
      field_accumulator <= field_accumulator_next;
      file_size_field   <= file_size_field_next;
      name_size_field   <= name_size_field_next;
      available_count   <= available_count_next;
      verdict_given     <= verdict_given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_verdict <= res_verdict_next;
      res_size    <= res_size_next;
    end
  end

  assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, res_size, res_verdict};

endmodule
